### rtl/bubble_sort_engine_core_assert.svh
// assertion macros for the bubble sort engine
// expects signals clk and rst_n in the including scope
`ifndef BUBBLE_SORT_ENGINE_CORE_ASSERT_SVH
`define BUBBLE_SORT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bubble sort engine assertion failed");

// next-cycle implication, checked outside reset
`define BSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bubble sort engine assertion failed");

`endif

### rtl/bse_pkg.sv
// shared constants, state type and command type for the bubble sort engine
// no dependencies
package bse_pkg;

    localparam int DEPTH   = 32;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_SORT,
        ST_EMIT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic             load_en;
        logic [IDX_W-1:0] load_idx;
        logic             sort_en;
        logic             odd_phase;
        logic [CNT_W-1:0] active_n;
        logic             shift_en;
    } dp_cmd_t;

endpackage

### rtl/bse_in_if.sv
// input channel of the bubble sort engine: value and last flag
// depends on bse_pkg
interface bse_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bse_pkg::DATA_W-1:0]   value;
    logic                                last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

### rtl/bse_out_if.sv
// result channel of the bubble sort engine: sorted value and flags
// depends on bse_pkg
interface bse_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bse_pkg::DATA_W-1:0]   sorted_value;
    logic                                final_res;
    logic                                truncated;

    modport source (output valid, output sorted_value, output final_res,
                    output truncated, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input truncated, output ready);
endinterface

### rtl/bubble_sort_engine_core.sv
// Bubble sort engine: collects signed 32-bit values until a beat with last set,
// sorts them ascending (stable) and returns them in order, final_res on the
// last one. Up to 32 values are held; further values of the same array are
// dropped and every result of that array carries truncated. The sort runs one
// odd-even transposition phase a cycle over a row of compare-swap lanes, and
// the store takes one value per cycle in and, while the receiver is ready,
// out. No input is taken while an array sorts or drains.
// Depends on bse_pkg, bse_in_if, bse_out_if, bse_ctrl, bse_datapath.
`include "bubble_sort_engine_core_assert.svh"

module bubble_sort_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    bse_in_if.sink      items,
    bse_out_if.source   results
);

    bse_pkg::dp_cmd_t cmd;

    // control
    bse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_last   (items.last),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .final_res (results.final_res),
        .truncated (results.truncated),
        .cmd       (cmd)
    );

    // storage and sort lanes
    bse_datapath u_dp (
        .clk   (clk),
        .cmd   (cmd),
        .value (items.value),
        .head  (results.sorted_value)
    );

    // input and output never open together
    `BSE_ASSERT_NOW(a_no_overlap, results.valid, !items.ready)
    // closing beat stops intake
    `BSE_ASSERT_NEXT(a_close_stops, items.valid && items.ready && items.last, !items.ready)
    // final result beat reopens intake
    `BSE_ASSERT_NEXT(a_final_reopens, results.valid && results.ready && results.final_res,
        items.ready && !results.valid)
    // results come out in ascending order
    `BSE_ASSERT_NEXT(a_ascending, results.valid && results.ready && !results.final_res,
        results.valid && (results.sorted_value >= $past(results.sorted_value)))

endmodule

### rtl/bse_ctrl.sv
// control state machine: collect, sort phases, emit
// depends on bse_pkg
module bse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              final_res,
    output logic              truncated,
    output bse_pkg::dp_cmd_t  cmd
);

    bse_pkg::state_t               state_reg, state_next;
    logic [bse_pkg::CNT_W-1:0]     fill_reg, fill_next;
    logic [bse_pkg::CNT_W-1:0]     phase_reg, phase_next;
    logic                          ovf_reg, ovf_next;
    logic                          in_beat;
    logic                          out_beat;
    logic                          has_room;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bse_pkg::ST_COLLECT;
            fill_reg  <= '0;
            phase_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            ovf_reg   <= ovf_next;
        end
    end

    // handshakes follow the state only
    assign in_ready  = (state_reg == bse_pkg::ST_COLLECT);
    assign out_valid = (state_reg == bse_pkg::ST_EMIT);
    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid && out_ready;
    assign has_room  = fill_reg < bse_pkg::CNT_W'(bse_pkg::DEPTH);

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        phase_next    = phase_reg;
        ovf_next      = ovf_reg;
        final_res     = 1'b0;
        truncated     = ovf_reg;
        cmd.load_en   = 1'b0;
        cmd.load_idx  = fill_reg[bse_pkg::IDX_W-1:0];
        cmd.sort_en   = 1'b0;
        cmd.odd_phase = phase_reg[0];
        cmd.active_n  = fill_reg;
        cmd.shift_en  = 1'b0;

        case (state_reg)
            bse_pkg::ST_COLLECT:
            begin
                if (in_beat)
                begin
                    // store while room is left, else drop and flag
                    if (has_room)
                    begin
                        cmd.load_en = 1'b1;
                        fill_next   = fill_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        phase_next = '0;
                        state_next = bse_pkg::ST_SORT;
                    end
                end
            end

            bse_pkg::ST_SORT:
            begin
                // n odd-even phases sort n elements
                cmd.sort_en = 1'b1;
                phase_next  = phase_reg + 1'b1;
                if (phase_reg == fill_reg - 1'b1)
                begin
                    state_next = bse_pkg::ST_EMIT;
                end
            end

            bse_pkg::ST_EMIT:
            begin
                final_res = (fill_reg == bse_pkg::CNT_W'(1));
                if (out_beat)
                begin
                    cmd.shift_en = 1'b1;
                    fill_next    = fill_reg - 1'b1;
                    if (final_res)
                    begin
                        ovf_next   = 1'b0;
                        state_next = bse_pkg::ST_COLLECT;
                    end
                end
            end

            default:
            begin
                state_next = bse_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

### rtl/bse_datapath.sv
// element store with odd-even compare-swap lanes and output shift
// depends on bse_pkg
module bse_datapath (
    input  logic                                clk,
    input  bse_pkg::dp_cmd_t                    cmd,
    input  logic signed [bse_pkg::DATA_W-1:0]   value,
    output logic signed [bse_pkg::DATA_W-1:0]   head
);

    logic signed [bse_pkg::DATA_W-1:0] store_reg  [bse_pkg::DEPTH];
    logic signed [bse_pkg::DATA_W-1:0] store_next [bse_pkg::DEPTH];

    // load, one compare-swap phase, or shift toward the head
    always_comb
    begin
        store_next = store_reg;
        if (cmd.load_en)
        begin
            store_next[cmd.load_idx] = value;
        end
        if (cmd.sort_en)
        begin
            for (int i = 0; i < bse_pkg::DEPTH - 1; i++)
            begin
                // pair (i, i+1) works on matching parity, inside the array
                if ((1'(i) == cmd.odd_phase)
                    && ((bse_pkg::CNT_W'(i) + 1'b1) < cmd.active_n)
                    && (store_reg[i] > store_reg[i+1]))
                begin
                    store_next[i]   = store_reg[i+1];
                    store_next[i+1] = store_reg[i];
                end
            end
        end
        if (cmd.shift_en)
        begin
            for (int i = 0; i < bse_pkg::DEPTH - 1; i++)
            begin
                store_next[i] = store_reg[i+1];
            end
        end
    end

    // element registers
    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    assign head = store_reg[0];

endmodule

### tb/tb_bubble_sort_engine_core.sv
// self-checking testbench for bubble_sort_engine_core: sends arrays of signed values,
// predicts the stable ascending order with truncation flags and checks every result beat
// depends on bse_pkg, bse_in_if, bse_out_if and the bubble_sort_engine_core rtl
module tb_bubble_sort_engine_core;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 200;

    typedef logic signed [bse_pkg::DATA_W-1:0] elem_t;

    typedef struct {
        elem_t sorted_value;
        logic  final_res;
        logic  truncated;
    } sorted_beat_t;

    typedef enum {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_BLOCKS
    } rx_pattern_t;

    typedef enum {
        VAL_FULL,
        VAL_CLUSTERED,
        VAL_EXTREME
    } value_style_t;

    localparam elem_t ELEM_MAX = {1'b0, {(bse_pkg::DATA_W-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(bse_pkg::DATA_W-1){1'b0}}};

    logic clk;
    logic rst_n;

    bse_in_if  items_ch();
    bse_out_if results_ch();

    bubble_sort_engine_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    elem_t        array_buffer[$];
    logic         array_dropped = 1'b0;
    sorted_beat_t sorted_expect[$];
    int           error_count   = 0;
    int           quiet_cycles  = 0;
    int           burst_left    = 0;
    bit           sender_gaps   = 1'b1;
    int           ready_cycle   = 0;
    rx_pattern_t  ready_mode    = RX_ALWAYS;

    // clock, period 2
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver stall pattern in one of four styles, picked anew at random
    always @(negedge clk)
    begin
        ready_cycle++;
        if (ready_cycle % 150 == 0)
            ready_mode = rx_pattern_t'($urandom_range(0, 3));
        case (ready_mode)
            RX_ALWAYS: results_ch.ready <= 1'b1;
            RX_RANDOM: results_ch.ready <= ($urandom_range(0, 9) < 6);
            RX_SPARSE: results_ch.ready <= (ready_cycle % 4 == 0);
            default:   results_ch.ready <= ((ready_cycle % 11) > 5);
        endcase
    end

    // predict on every input beat, check every result beat, watch for a hang
    always @(posedge clk)
    begin
        bit           moved;
        int           pos;
        elem_t        sorted_run[$];
        sorted_beat_t want;

        moved = 1'b0;
        if (rst_n)
        begin
            // input beat: buffer or drop, and on last emit the sorted array
            if (items_ch.valid && items_ch.ready === 1'b1)
            begin
                moved = 1'b1;
                if (array_buffer.size() < bse_pkg::DEPTH)
                    array_buffer.push_back(items_ch.value);
                else
                    array_dropped = 1'b1;
                if (items_ch.last)
                begin
                    // insertion with strict compare keeps equal values in arrival order
                    sorted_run = {};
                    foreach (array_buffer[i])
                    begin
                        pos = sorted_run.size();
                        while (pos > 0 && sorted_run[pos-1] > array_buffer[i])
                            pos--;
                        sorted_run.insert(pos, array_buffer[i]);
                    end
                    foreach (sorted_run[k])
                        sorted_expect.push_back('{sorted_run[k],
                                                  k == sorted_run.size() - 1,
                                                  array_dropped});
                    array_buffer  = {};
                    array_dropped = 1'b0;
                end
            end

            // result beat: compare with the oldest expectation
            if (results_ch.valid === 1'b1 && results_ch.ready)
            begin
                moved = 1'b1;
                if (sorted_expect.size() == 0)
                begin
                    $error("result beat with nothing expected: sorted_value %0d",
                           results_ch.sorted_value);
                    error_count++;
                end
                else
                begin
                    want = sorted_expect.pop_front();
                    if (results_ch.sorted_value !== want.sorted_value)
                    begin
                        $error("sorted_value: expected %0d, got %0d",
                               want.sorted_value, results_ch.sorted_value);
                        error_count++;
                    end
                    if (results_ch.final_res !== want.final_res)
                    begin
                        $error("final_res: expected %0b, got %0b",
                               want.final_res, results_ch.final_res);
                        error_count++;
                    end
                    if (results_ch.truncated !== want.truncated)
                    begin
                        $error("truncated: expected %0b, got %0b",
                               want.truncated, results_ch.truncated);
                        error_count++;
                    end
                end
            end

            // watchdog on cycles without any beat
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // one input beat, with a random gap between bursts
    task automatic send_value(input elem_t value, input logic last);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap        = $urandom_range(1, 5);
            @(negedge clk);
            items_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        items_ch.valid <= 1'b1;
        items_ch.value <= value;
        items_ch.last  <= last;
        do
            @(posedge clk);
        while (items_ch.ready !== 1'b1);
        if (burst_left > 0)
            burst_left--;
    endtask

    // whole array, last flag on the final element
    task automatic send_array(input elem_t vals[$]);
        foreach (vals[i])
            send_value(vals[i], i == vals.size() - 1);
    endtask

    // hold the input idle until every expected result has come out
    task automatic wait_for_drain();
        @(negedge clk);
        items_ch.valid <= 1'b0;
        while (sorted_expect.size() != 0)
            @(posedge clk);
    endtask

    // one-element arrays at the ends of the range
    task automatic test_single_element();
        elem_t vals[$];
        vals = {ELEM_MAX};
        send_array(vals);
        vals = {ELEM_MIN};
        send_array(vals);
        vals = {elem_t'(0)};
        send_array(vals);
        vals = {elem_t'(-1)};
        send_array(vals);
    endtask

    // both signs, extremes and alternating bit patterns, with duplicates
    task automatic test_mixed_signs();
        elem_t vals[$];
        vals = {elem_t'(0), ELEM_MAX, elem_t'(-1), ELEM_MIN, elem_t'(1),
                ELEM_MIN, ELEM_MAX, elem_t'(32'sh5555_5555), elem_t'(32'shAAAA_AAAA)};
        send_array(vals);
    endtask

    // reverse order and all-equal arrays
    task automatic test_ordered_inputs();
        elem_t vals[$];
        vals = {elem_t'(5), elem_t'(4), elem_t'(3), elem_t'(2), elem_t'(1),
                elem_t'(0), elem_t'(-1)};
        send_array(vals);
        vals = {elem_t'(7), elem_t'(7), elem_t'(7), elem_t'(7)};
        send_array(vals);
    endtask

    // full buffer: the closing element itself is dropped but still ends the array
    task automatic test_overflow();
        elem_t vals[$];
        repeat (bse_pkg::DEPTH + 1)
            vals.push_back(elem_t'($urandom));
        send_array(vals);
    endtask

    // pause the sender with results outstanding, then resume back to back
    task automatic test_drain_pause();
        elem_t vals[$];
        repeat (6)
            vals.push_back(elem_t'($urandom_range(0, 20)) - 10);
        send_array(vals);
        wait_for_drain();
        sender_gaps = 1'b0;
        send_array(vals);
        sender_gaps = 1'b1;
    endtask

    // random arrays: mostly short, some full and some past capacity
    task automatic test_random_arrays(input int budget);
        int           sent;
        int           len;
        int           pick;
        value_style_t style;
        elem_t        vals[$];
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                len = $urandom_range(1, 8);
            else if (pick < 85)
                len = $urandom_range(9, bse_pkg::DEPTH - 1);
            else if (pick < 92)
                len = bse_pkg::DEPTH;
            else
                len = $urandom_range(bse_pkg::DEPTH + 1, bse_pkg::DEPTH + 8);
            sender_gaps = ($urandom_range(0, 3) != 0);
            style       = value_style_t'($urandom_range(0, 2));
            vals        = {};
            repeat (len)
            begin
                case (style)
                    VAL_FULL:      vals.push_back(elem_t'($urandom));
                    VAL_CLUSTERED: vals.push_back(elem_t'($urandom_range(0, 8)) - 4);
                    default:
                    begin
                        case ($urandom_range(0, 4))
                            0:       vals.push_back(ELEM_MIN);
                            1:       vals.push_back(ELEM_MAX);
                            2:       vals.push_back(elem_t'(0));
                            3:       vals.push_back(elem_t'(-1));
                            default: vals.push_back(elem_t'($urandom));
                        endcase
                    end
                endcase
            end
            send_array(vals);
            sent += len;
            if ($urandom_range(0, 9) == 0)
                wait_for_drain();
        end
    endtask

    // reset, tests in turn, final drain and verdict
    initial
    begin
        rst_n            = 1'b0;
        items_ch.valid   = 1'b0;
        items_ch.value   = '0;
        items_ch.last    = 1'b0;
        results_ch.ready = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_single_element();
        test_mixed_signs();
        test_ordered_inputs();
        test_overflow();
        test_drain_pause();
        test_random_arrays(380);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sorted_expect.size() != 0)
        begin
            $error("%0d expected result beats never arrived", sorted_expect.size());
            error_count++;
        end
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/bse_pkg.sv
rtl/bse_in_if.sv
rtl/bse_out_if.sv
rtl/bse_ctrl.sv
rtl/bse_datapath.sv
rtl/bubble_sort_engine_core.sv
tb/tb_bubble_sort_engine_core.sv
